### rtl/two_pole_lattice_resonator_unit_assert.svh
`ifndef TWO_POLE_LATTICE_RESONATOR_UNIT_ASSERT_SVH
`define TWO_POLE_LATTICE_RESONATOR_UNIT_ASSERT_SVH

// check while out of reset
`define TPLR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// check on every edge, reset included
`define TPLR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

### rtl/tplr_pkg.sv
package tplr_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int STATE_W   = 48;
  localparam int C1_W      = 18;
  localparam int C2_W      = 19;
  localparam int MUL_A_W   = 25;
  localparam int PROD_W    = MUL_A_W + C2_W;
  localparam int ACC_W     = STATE_W + C2_W;
  localparam int ALU_W     = 52;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = C2_W;

  localparam logic [CFG_IDX_W-1:0] REG_POLE_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_COEF = 2'd1;

  localparam logic [C1_W-1:0]        POLE_RADIUS_RST  = 18'd65536;
  localparam logic signed [C2_W-1:0] LATTICE_COEF_RST = 19'sd13107;

  localparam logic signed [SAMPLE_W-1:0] MAX24 = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] MIN24 = 24'sh800000;
  localparam logic signed [STATE_W-1:0]  MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [STATE_W-1:0]  MIN48 = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [ALU_W-1:0] op_a;
    logic signed [ALU_W-1:0] op_b;
    logic                    sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] res;
    logic                      sat;
  } alu_rsp_t;

  function automatic logic signed [ALU_W-1:0] ext48(input logic signed [STATE_W-1:0] v);
    return {{(ALU_W-STATE_W){v[STATE_W-1]}}, v};
  endfunction

endpackage

### rtl/tplr_if.sv
interface tplr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tplr_pkg::SAMPLE_W-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface tplr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tplr_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                  clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### rtl/two_pole_lattice_resonator_unit.sv
// channel  | direction | payload                      | handshake
// in_ch    | in        | sample_in                    | valid / ready
// out_ch   | out       | sample_out, clipped          | valid / ready
// cfg_*    | in        | cfg_index, cfg_wdata         | cfg_we, no wait
//
// A new item is taken only once the last result has gone to the output register.
// The steps come from one 25x19 multiplier used six times (three 48-bit products,
// two halves each) and one saturating 52-bit adder used six times.
// in_ch.ready is high only while the sequencer is idle.
// A result waits in the output register; the last step holds while it is not taken.
// Synchronous reset clears both delay words, the clip flag and the output valid.
module two_pole_lattice_resonator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  tplr_in_if.sink                             in_ch,
  tplr_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [tplr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tplr_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int SW = tplr_pkg::STATE_W;
  localparam int AW = tplr_pkg::ACC_W;
  localparam int LW = tplr_pkg::ALU_W;
  localparam int PW = tplr_pkg::PROD_W;
  localparam int XW = tplr_pkg::SAMPLE_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_A_LO  = 4'd1;
  localparam logic [3:0] ST_A_HI  = 4'd2;
  localparam logic [3:0] ST_B_LO  = 4'd3;
  localparam logic [3:0] ST_B_HI  = 4'd4;
  localparam logic [3:0] ST_B_ACC = 4'd5;
  localparam logic [3:0] ST_B_SAT = 4'd6;
  localparam logic [3:0] ST_D     = 4'd7;
  localparam logic [3:0] ST_M_LO  = 4'd8;
  localparam logic [3:0] ST_M_HI  = 4'd9;
  localparam logic [3:0] ST_M_ACC = 4'd10;
  localparam logic [3:0] ST_M_SAT = 4'd11;
  localparam logic [3:0] ST_Y     = 4'd12;
  localparam logic [3:0] ST_S2    = 4'd13;

  localparam logic signed [AW-1:0] HALF18 = 67'sd131072;
  localparam logic signed [AW-1:0] HALF17 = 67'sd65536;

  logic [3:0]                      state_r;
  logic [3:0]                      state_nxt;
  logic [tplr_pkg::C1_W-1:0]       pole_radius_r;
  logic signed [tplr_pkg::C2_W-1:0] lattice_coef_r;
  logic signed [SW-1:0]            first_delay_r;
  logic signed [SW-1:0]            second_delay_r;
  logic signed [XW-1:0]            x_r;
  logic signed [AW-1:0]            acc_r;
  logic signed [SW-1:0]            a_r;
  logic signed [SW-1:0]            b_r;
  logic signed [SW-1:0]            d_r;
  logic signed [SW-1:0]            m_r;
  logic                            flag_r;
  logic                            out_valid_r;
  logic signed [XW-1:0]            out_sample_r;
  logic                            out_clipped_r;

  logic                            in_take;
  logic                            out_free;
  logic                            finish;
  logic signed [tplr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tplr_pkg::C2_W-1:0]    mul_b;
  logic signed [PW-1:0]            prod;
  logic signed [AW-1:0]            prod_ext;
  logic signed [LW-1:0]            rnd18;
  logic signed [LW-1:0]            rnd17;
  tplr_pkg::alu_req_t              alu_req;
  tplr_pkg::alu_rsp_t              alu_rsp;
  logic                            clip24;
  logic signed [XW-1:0]            y24;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_take        = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign finish         = (state_r == ST_S2) && out_free;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.clipped    = out_clipped_r;

  assign prod_ext = {{(AW-PW){prod[PW-1]}}, prod};
  assign rnd18    = {{(LW-(AW-18)){acc_r[AW-1]}}, acc_r[AW-1:18]};
  assign rnd17    = {{(LW-(AW-17)){acc_r[AW-1]}}, acc_r[AW-1:17]};

  assign clip24 = !((&first_delay_r[SW-1:XW-1]) || (~|first_delay_r[SW-1:XW-1]));
  assign y24    = clip24 ? (first_delay_r[SW-1] ? tplr_pkg::MIN24 : tplr_pkg::MAX24)
                         : first_delay_r[XW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_A_LO: begin
        mul_a = {1'b0, second_delay_r[23:0]};
        mul_b = {1'b0, pole_radius_r};
      end
      ST_A_HI: begin
        mul_a = {second_delay_r[SW-1], second_delay_r[SW-1:24]};
        mul_b = {1'b0, pole_radius_r};
      end
      ST_B_LO: begin
        mul_a = {1'b0, first_delay_r[23:0]};
        mul_b = {1'b0, pole_radius_r};
      end
      ST_B_HI: begin
        mul_a = {first_delay_r[SW-1], first_delay_r[SW-1:24]};
        mul_b = {1'b0, pole_radius_r};
      end
      ST_M_LO: begin
        mul_a = {1'b0, d_r[23:0]};
        mul_b = lattice_coef_r;
      end
      ST_M_HI: begin
        mul_a = {d_r[SW-1], d_r[SW-1:24]};
        mul_b = lattice_coef_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_B_HI: begin
        alu_req.op_a = {{(LW-XW){x_r[XW-1]}}, x_r};
        alu_req.op_b = rnd18;
      end
      ST_B_SAT: begin
        alu_req.op_b = rnd18;
        alu_req.sub  = 1'b1;
      end
      ST_D: begin
        alu_req.op_a = tplr_pkg::ext48(a_r);
        alu_req.op_b = tplr_pkg::ext48(b_r);
        alu_req.sub  = 1'b1;
      end
      ST_M_SAT: begin
        alu_req.op_b = rnd17;
      end
      ST_Y: begin
        alu_req.op_a = tplr_pkg::ext48(m_r);
        alu_req.op_b = tplr_pkg::ext48(a_r);
      end
      ST_S2: begin
        alu_req.op_a = tplr_pkg::ext48(b_r);
        alu_req.op_b = tplr_pkg::ext48(m_r);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_A_LO;
        end
      end
      ST_S2: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = state_r + 4'd1;
      end
    endcase
  end

  tplr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  tplr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pole_radius_r  <= tplr_pkg::POLE_RADIUS_RST;
      lattice_coef_r <= tplr_pkg::LATTICE_COEF_RST;
      first_delay_r  <= '0;
      second_delay_r <= '0;
      flag_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tplr_pkg::REG_POLE_RADIUS:  pole_radius_r  <= cfg_wdata[tplr_pkg::C1_W-1:0];
          tplr_pkg::REG_LATTICE_COEF: lattice_coef_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_take) begin
        flag_r <= 1'b0;
      end else if (state_r == ST_B_HI || state_r == ST_B_SAT || state_r == ST_D ||
                   state_r == ST_M_SAT || state_r == ST_Y) begin
        flag_r <= flag_r | alu_rsp.sat;
      end
      if (state_r == ST_Y) begin
        first_delay_r <= alu_rsp.res;
      end
      if (finish) begin
        second_delay_r <= alu_rsp.res;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_ch.sample_in;
    end
    unique case (state_r)
      ST_A_HI:  acc_r <= prod_ext + HALF18;
      ST_B_LO:  acc_r <= acc_r + (prod_ext <<< 24);
      ST_B_HI:  acc_r <= prod_ext + HALF18;
      ST_B_ACC: acc_r <= acc_r + (prod_ext <<< 24);
      ST_M_HI:  acc_r <= prod_ext + HALF17;
      ST_M_ACC: acc_r <= acc_r + (prod_ext <<< 24);
      default: ;
    endcase
    if (state_r == ST_B_HI) begin
      a_r <= alu_rsp.res;
    end
    if (state_r == ST_B_SAT) begin
      b_r <= alu_rsp.res;
    end
    if (state_r == ST_D) begin
      d_r <= alu_rsp.res;
    end
    if (state_r == ST_M_SAT) begin
      m_r <= alu_rsp.res;
    end
    if (finish) begin
      out_sample_r  <= y24;
      out_clipped_r <= flag_r | alu_rsp.sat | clip24;
    end
  end

endmodule

### rtl/tplr_mul.sv
module tplr_mul (
  input  logic                                 clk,
  input  logic signed [tplr_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [tplr_pkg::C2_W-1:0]     op_b,
  output logic signed [tplr_pkg::PROD_W-1:0]   prod
);

  logic signed [tplr_pkg::PROD_W-1:0] prod_r;
  logic signed [tplr_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = tplr_pkg::PROD_W'(op_a) * tplr_pkg::PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

### rtl/tplr_alu.sv
module tplr_alu (
  input  tplr_pkg::alu_req_t req,
  output tplr_pkg::alu_rsp_t rsp
);

  localparam int SUM_W = tplr_pkg::ALU_W + 1;
  localparam int TOP_W = SUM_W - tplr_pkg::STATE_W + 1;

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] sum;
  logic [TOP_W-1:0]        top;
  logic                    ovf;

  assign a_ext = {req.op_a[tplr_pkg::ALU_W-1], req.op_a};
  assign b_ext = {req.op_b[tplr_pkg::ALU_W-1], req.op_b};
  assign sum   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);
  assign top   = sum[SUM_W-1:tplr_pkg::STATE_W-1];
  assign ovf   = !((&top) || (~|top));

  always_comb begin
    rsp.sat = ovf;
    if (!ovf) begin
      rsp.res = sum[tplr_pkg::STATE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      rsp.res = tplr_pkg::MIN48;
    end else begin
      rsp.res = tplr_pkg::MAX48;
    end
  end

endmodule

### rtl/tplr_checker.sv
`include "two_pole_lattice_resonator_unit_assert.svh"

module tplr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tplr_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_clipped
);

  `TPLR_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `TPLR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
  `TPLR_ASSERT(a_busy_after_take, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `TPLR_ASSERT(a_result_frees_input, clk, rst_n, $rose(out_valid) |-> in_ready)

endmodule

bind two_pole_lattice_resonator_unit tplr_checker u_tplr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_sample  (out_ch.sample_out),
  .out_clipped (out_ch.clipped)
);

### test/resonator_checker.sv
`timescale 1ns / 100ps

module resonator_checker
  import tplr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       out_clipped,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output int                         mismatches,
  output int                         pending
);

  localparam int WIDE_W = 72;
  localparam logic signed [WIDE_W-1:0] WIDE_ONE = 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } filtered_t;

  filtered_t                  expected_q[$];
  logic signed [STATE_W-1:0]  s1;
  logic signed [STATE_W-1:0]  s2;
  logic [C1_W-1:0]            radius;
  logic signed [C2_W-1:0]     coef;
  filtered_t                  want;
  filtered_t                  fresh;

  function automatic logic signed [WIDE_W-1:0] scaled_product(
    input logic signed [STATE_W-1:0] s,
    input logic signed [C2_W-1:0]    c,
    input int                        sh
  );
    logic signed [WIDE_W-1:0] p;
    p = s * c;
    p = p + (WIDE_ONE <<< (sh - 1));
    return p >>> sh;
  endfunction

  function automatic logic signed [STATE_W-1:0] clamp48(
    input logic signed [WIDE_W-1:0] v,
    inout logic                     flag
  );
    if (v > MAX48) begin
      flag = 1'b1;
      return MAX48;
    end
    if (v < MIN48) begin
      flag = 1'b1;
      return MIN48;
    end
    return v[STATE_W-1:0];
  endfunction

  task automatic resonate(input logic signed [SAMPLE_W-1:0] x, output filtered_t res);
    logic                      clip;
    logic signed [C2_W-1:0]    c1;
    logic signed [WIDE_W-1:0]  wa;
    logic signed [WIDE_W-1:0]  wb;
    logic signed [WIDE_W-1:0]  wd;
    logic signed [WIDE_W-1:0]  wm;
    logic signed [STATE_W-1:0] a;
    logic signed [STATE_W-1:0] b;
    logic signed [STATE_W-1:0] d;
    logic signed [STATE_W-1:0] m;
    logic signed [STATE_W-1:0] y;
    logic signed [STATE_W-1:0] s2n;
    clip = 1'b0;
    c1 = $signed({1'b0, radius});
    wa = x;
    wa = wa + scaled_product(s2, c1, 18);
    a = clamp48(wa, clip);
    wb = -scaled_product(s1, c1, 18);
    b = clamp48(wb, clip);
    wa = a;
    wb = b;
    wd = wa - wb;
    d = clamp48(wd, clip);
    wm = scaled_product(d, coef, 17);
    m = clamp48(wm, clip);
    wm = m;
    y = clamp48(wm + wa, clip);
    s2n = clamp48(wb + wm, clip);
    s1 = y;
    s2 = s2n;
    if (y > MAX24) begin
      res.sample = MAX24;
      clip = 1'b1;
    end else if (y < MIN24) begin
      res.sample = MIN24;
      clip = 1'b1;
    end else begin
      res.sample = y[SAMPLE_W-1:0];
    end
    res.clipped = clip;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      s1 = '0;
      s2 = '0;
      radius = POLE_RADIUS_RST;
      coef = LATTICE_COEF_RST;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLE_RADIUS: begin
            radius = cfg_wdata[C1_W-1:0];
          end
          REG_LATTICE_COEF: begin
            coef = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        resonate(in_sample, fresh);
        expected_q.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: item with none expected: sample_out %0d clipped %0b",
                   $time, out_sample, out_clipped);
        end else begin
          want = expected_q.pop_front();
          if (out_sample !== want.sample) begin
            mismatches++;
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, want.sample, out_sample);
          end
          if (out_clipped !== want.clipped) begin
            mismatches++;
            $display("%0t: clipped expected %0b actual %0b",
                     $time, want.clipped, out_clipped);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### test/tb_two_pole_lattice_resonator_unit.sv
`timescale 1ns / 100ps

module tb_two_pole_lattice_resonator_unit;
  import tplr_pkg::*;

  localparam int LIMIT = 600000;
  localparam int ITEMS_PER_SETTING = 135;
  localparam int SETTINGS = 8;
  localparam int HOLD_AT = 900;
  localparam int HOLD_LEN = 300;
  localparam int DRAIN = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   pending;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   sent_count;
  int                   cycle_count;

  logic signed [SAMPLE_W-1:0] directed [22] = '{
    24'sd0, MAX24, MIN24, 24'sd1, -24'sd1, MAX24, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
    MIN24, MIN24, MIN24, MIN24, MAX24, MIN24, MAX24, MIN24,
    24'sh555555, -24'sh555556, 24'sd4096, -24'sd4096
  };

  tplr_in_if  in_bus ();
  tplr_out_if out_bus ();

  two_pole_lattice_resonator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  resonator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_sample   (in_bus.sample_in),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_sample  (out_bus.sample_out),
    .out_clipped (out_bus.clipped),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    int          k;
    int          v;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        return r[SAMPLE_W-1:0];
      end
      4, 5: begin
        k = $urandom_range(1, 22);
        v = int'($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1));
        return v[SAMPLE_W-1:0];
      end
      6: begin
        return r[0] ? MAX24 : MIN24;
      end
      7: begin
        return 24'sd0;
      end
      8: begin
        return r[0] ? 24'sd1 : -24'sd1;
      end
      default: begin
        if (r[8])
          v = int'(MAX24) - int'(r[7:0]);
        else
          v = int'(MIN24) + int'(r[7:0]);
        return v[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v);
    if (sent_count < 370) begin
      send_idle_pct = 29;
      recv_idle_pct = 80;
    end else if (sent_count < 740) begin
      send_idle_pct = 80;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample_in <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] radius_word;
    logic [CFG_W-1:0] coef_word;
    logic [31:0]      r;
    int               c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.sample_in = '0;
    send_idle_pct = 29;
    recv_idle_pct = 80;
    sent_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) offer_sample(directed[i]);

    for (int s = 0; s < SETTINGS; s++) begin
      case (s)
        0: begin
          radius_word = {1'b0, POLE_RADIUS_RST};
          coef_word = LATTICE_COEF_RST;
        end
        1: begin
          radius_word = 19'd261881;
          coef_word = 19'sd131072;
        end
        2: begin
          radius_word = 19'd0;
          coef_word = -19'sd131072;
        end
        3: begin
          radius_word = {1'b1, 18'h3FFFF};
          coef_word = 19'sd131072;
        end
        4: begin
          radius_word = 19'd200000;
          coef_word = -19'sd262144;
        end
        5: begin
          radius_word = 19'd131072;
          coef_word = 19'sd262143;
        end
        6: begin
          r = $urandom_range(0, 261881);
          radius_word = r[CFG_W-1:0];
          c = int'($urandom_range(0, 262144)) - 131072;
          coef_word = c[CFG_W-1:0];
        end
        default: begin
          radius_word = 19'd250000;
          coef_word = 19'sd0;
        end
      endcase
      in_bus.valid <= 1'b0;
      wait_drained();
      r = $urandom;
      write_register(r[31] ? REG_SPARE_A : REG_SPARE_B, r[CFG_W-1:0]);
      write_register(REG_POLE_RADIUS, radius_word);
      write_register(REG_LATTICE_COEF, coef_word);
      repeat (ITEMS_PER_SETTING) offer_sample(pick_sample());
    end

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
